[rtl/bsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants for the BASIC source lexer.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int unsigned VALUE_MAX_DEF = 32'd2147483647;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 2;
    localparam int VALUE_W = 31;

    localparam logic REC_CHAR = 1'b0;
    localparam logic REC_END  = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_PLAIN = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_LIT   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_INT   = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              end_of_text;
    } t_in_item;

    typedef struct packed {
        logic               rec_kind;
        logic [CHAR_W-1:0]  char_out;
        logic [CLASS_W-1:0] token_class;
        logic [VALUE_W-1:0] int_value;
        logic               last;
    } t_out_item;

    // Records caused by one item, in order: close, content char, plain end.
    typedef struct packed {
        logic               has_close;
        logic [CLASS_W-1:0] close_class;
        logic [VALUE_W-1:0] close_value;
        logic               has_char;
        logic [CHAR_W-1:0]  ch;
        logic               has_end;
    } t_bundle;

endpackage

[rtl/bsl_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface bsl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/basic_source_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_source_lexer
// Splits a stream of source characters into BASIC tokens: content
// characters followed by one token end record each.
// The first result of an item is registered and valid in the cycle after it is accepted.
// Accepts one item per cycle while each item causes at most one record and
// the output is ready; an item causing two or three records holds off the
// next item until the single output channel drains the result register.
// Reset (synchronous, active low): lexer idle, no token open, output empty.
// ----------------------------------------------------------------------------
module basic_source_lexer #(
    parameter int unsigned VALUE_MAX = bsl_pkg::VALUE_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsl_stream_if.sink   i_in,
    bsl_stream_if.source o_out
);

    bsl_pkg::t_bundle bundle;
    logic             fire;
    logic             free;
    logic             load;

    assign i_in.ready = free;
    assign fire       = i_in.valid && free;
    assign load       = fire && (bundle.has_close || bundle.has_char || bundle.has_end);

    bsl_core #(
        .VALUE_MAX (VALUE_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (i_in.payload),
        .o_bundle (bundle)
    );

    bsl_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .o_free   (free),
        .o_out    (o_out)
    );

endmodule

[rtl/bsl_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_core
// Lexer state machine: classifies one character per item, updates the mode
// and integer accumulator, and builds the record bundle for that item.
// ----------------------------------------------------------------------------
module bsl_core #(
    parameter int unsigned VALUE_MAX = bsl_pkg::VALUE_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bsl_pkg::t_in_item i_item,
    output bsl_pkg::t_bundle  o_bundle
);

    localparam int VW = bsl_pkg::VALUE_W;
    localparam logic [VW:0]   MAX_EXT = (VW+1)'(VALUE_MAX);
    localparam logic [VW-1:0] DIV10   = VW'(VALUE_MAX / 10);

    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_ONE   = 8'h31;
    localparam logic [7:0] C_SEVEN = 8'h37;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [7:0] C_UP_E  = 8'h45;
    localparam logic [7:0] C_LO_E  = 8'h65;
    localparam logic [7:0] C_UP_X  = 8'h58;
    localparam logic [7:0] C_LO_X  = 8'h78;
    localparam logic [7:0] C_UP_O  = 8'h4F;
    localparam logic [7:0] C_LO_O  = 8'h6F;
    localparam logic [7:0] C_UP_H  = 8'h48;
    localparam logic [7:0] C_LO_H  = 8'h68;

    typedef enum logic [3:0] {
        M_IDLE, M_WS, M_IDENT, M_LIT, M_QUOTE, M_INT, M_FRAC, M_EXPS,
        M_EXPSIGN, M_EXPD, M_TRAIL, M_AMP, M_BIN, M_OCT, M_HEX
    } t_mode;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == C_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    t_mode          r_mode, n_mode;
    logic [VW-1:0]  r_acc, n_acc;
    logic           r_still, n_still;
    logic           r_ovf, n_ovf;

    logic [7:0]     c;
    logic           eot;
    logic           take;
    logic           do_close;
    logic           do_start;
    logic [VW-1:0]  acc10;
    logic [VW:0]    acc_sum;
    logic [3:0]     digit;

    assign c     = i_item.ch;
    assign eot   = i_item.end_of_text || (i_item.ch == 8'h00);
    assign digit = c[3:0];
    assign acc10 = (r_acc << 3) + (r_acc << 1);
    assign acc_sum = {1'b0, acc10} + (VW+1)'(digit);

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_still  = r_still;
        n_ovf    = r_ovf;
        o_bundle = '0;
        o_bundle.ch = c;
        take     = 1'b0;
        do_close = 1'b0;
        do_start = 1'b0;

        if (eot) begin
            do_close = (r_mode != M_IDLE);
        end else begin
            unique case (r_mode)
                M_IDLE: ;
                M_WS: begin
                    take = is_space(c);
                end
                M_IDENT: begin
                    if (is_ident(c)) begin
                        take = 1'b1;
                    end else if (c == C_DOLLAR) begin
                        take = 1'b1;
                        o_bundle.has_end = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_LIT: begin
                    take = 1'b1;
                    if (c == C_QUOTE) begin
                        n_mode = M_QUOTE;
                    end
                end
                M_QUOTE: begin
                    if (c == C_QUOTE) begin
                        take = 1'b1;
                        n_mode = M_LIT;
                    end
                end
                M_INT, M_FRAC: begin
                    if ((r_mode == M_INT) && is_digit(c)) begin
                        take = 1'b1;
                        if (!r_ovf) begin
                            if (r_acc > DIV10) begin
                                n_ovf = 1'b1;
                            end else if (acc_sum > MAX_EXT) begin
                                n_ovf = 1'b1;
                                n_acc = acc10;
                            end else begin
                                n_acc = acc_sum[VW-1:0];
                            end
                        end
                    end else if ((r_mode == M_INT) && (c == C_DOT)) begin
                        take = 1'b1;
                        n_still = 1'b0;
                        n_mode = M_FRAC;
                    end else if ((r_mode == M_FRAC) && is_digit(c)) begin
                        take = 1'b1;
                    end else if ((c == C_LO_E) || (c == C_UP_E)) begin
                        take = 1'b1;
                        n_still = 1'b0;
                        n_mode = M_EXPS;
                    end else if (is_ident(c)) begin
                        take = 1'b1;
                        n_still = 1'b0;
                        n_mode = M_TRAIL;
                    end
                end
                M_EXPS: begin
                    if (is_digit(c)) begin
                        take = 1'b1;
                        n_mode = M_EXPD;
                    end else if ((c == C_PLUS) || (c == C_MINUS)) begin
                        take = 1'b1;
                        n_mode = M_EXPSIGN;
                    end else if (is_ident(c)) begin
                        take = 1'b1;
                        n_mode = M_TRAIL;
                    end
                end
                M_EXPSIGN, M_EXPD: begin
                    if (is_digit(c)) begin
                        take = 1'b1;
                        n_mode = M_EXPD;
                    end else if (is_ident(c)) begin
                        take = 1'b1;
                        n_mode = M_TRAIL;
                    end
                end
                M_TRAIL: begin
                    take = is_ident(c);
                end
                M_AMP: begin
                    if ((c == C_LO_X) || (c == C_UP_X)) begin
                        take = 1'b1;
                        n_mode = M_BIN;
                    end else if ((c == C_LO_O) || (c == C_UP_O)) begin
                        take = 1'b1;
                        n_mode = M_OCT;
                    end else if ((c == C_LO_H) || (c == C_UP_H) || is_xdigit(c)) begin
                        take = 1'b1;
                        n_mode = M_HEX;
                    end
                end
                M_BIN: begin
                    take = (c == C_ZERO) || (c == C_ONE);
                end
                M_OCT: begin
                    take = (c >= C_ZERO) && (c <= C_SEVEN);
                end
                M_HEX: begin
                    take = is_xdigit(c);
                end
                default: ;
            endcase

            // Content is emitted for every taken char except a literal quote.
            if (take) begin
                o_bundle.has_char = !((r_mode == M_LIT) && (c == C_QUOTE));
            end else begin
                do_close = (r_mode == M_IDLE) ? 1'b0 : (r_mode <= M_HEX);
                do_start = 1'b1;
            end
        end

        if (do_close) begin
            o_bundle.has_close = 1'b1;
            if ((r_mode == M_LIT) || (r_mode == M_QUOTE)) begin
                o_bundle.close_class = bsl_pkg::CLASS_LIT;
            end else if ((r_mode == M_INT) && r_still && !r_ovf) begin
                o_bundle.close_class = bsl_pkg::CLASS_INT;
                o_bundle.close_value = r_acc;
            end else begin
                o_bundle.close_class = bsl_pkg::CLASS_PLAIN;
            end
        end

        if (eot || do_start || (n_mode == M_IDLE)) begin
            n_mode  = M_IDLE;
            n_acc   = '0;
            n_still = 1'b1;
            n_ovf   = 1'b0;
        end

        if (do_start) begin
            o_bundle.has_char = 1'b1;
            if (is_space(c)) begin
                n_mode = M_WS;
            end else if (is_alpha(c)) begin
                n_mode = M_IDENT;
            end else if (c == C_QUOTE) begin
                o_bundle.has_char = 1'b0;
                n_mode = M_LIT;
            end else if (is_digit(c)) begin
                n_acc  = VW'(digit);
                n_mode = M_INT;
            end else if (c == C_DOT) begin
                n_still = 1'b0;
                n_mode  = M_FRAC;
            end else if (c == C_AMP) begin
                n_mode = M_AMP;
            end else begin
                o_bundle.has_end = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_still <= 1'b1;
            r_ovf   <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_still <= n_still;
            r_ovf   <= n_ovf;
        end
    end

endmodule

[rtl/bsl_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_outq
// Result register: holds the record bundle of one item and hands its
// records out one per transfer, flagging the final one.
// ----------------------------------------------------------------------------
module bsl_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bsl_pkg::t_bundle    i_bundle,
    output logic                o_free,
    bsl_stream_if.source        o_out
);

    logic [2:0]       r_pend, n_pend;
    bsl_pkg::t_bundle r_bundle;
    logic [2:0]       cur;
    logic             is_last;
    logic             xfer;

    // Lowest pending record goes first.
    assign cur     = r_pend & (~r_pend + 3'd1);
    assign is_last = (r_pend == cur);
    assign xfer    = o_out.valid && o_out.ready;
    assign o_free  = (r_pend == 3'b000) || (xfer && is_last);

    assign o_out.valid = (r_pend != 3'b000);

    always_comb begin
        o_out.payload = '0;
        o_out.payload.last = is_last;
        if (cur[0]) begin
            o_out.payload.rec_kind    = bsl_pkg::REC_END;
            o_out.payload.token_class = r_bundle.close_class;
            o_out.payload.int_value   = r_bundle.close_value;
        end else if (cur[1]) begin
            o_out.payload.rec_kind = bsl_pkg::REC_CHAR;
            o_out.payload.char_out = r_bundle.ch;
        end else begin
            o_out.payload.rec_kind    = bsl_pkg::REC_END;
            o_out.payload.token_class = bsl_pkg::CLASS_PLAIN;
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (xfer) begin
            n_pend = r_pend & ~cur;
        end
        if (i_load) begin
            n_pend = {i_bundle.has_end, i_bundle.has_char, i_bundle.has_close};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule
